// ===== hw/rtl/connection_admission_limiter_unit_defines.svh =====
`ifndef CONNECTION_ADMISSION_LIMITER_UNIT_DEFINES_SVH
`define CONNECTION_ADMISSION_LIMITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("connection admission limiter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("connection admission limiter check failed");

`endif

// ===== hw/rtl/cal_pkg.sv =====
`timescale 1ns / 1ps

package cal_pkg;

  localparam int unsigned TableEntries = 64;

  localparam int unsigned AddrHalfW = 64;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned PerAddrW  = 16;
  localparam int unsigned CntW      = 17;
  localparam int unsigned LimTotalW = TotalW + 1;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam int unsigned MgmtTotalBonus = 100;
  localparam int unsigned MgmtAddrBonus  = 10;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTooMany   = 3'd1,
    StPerAddr   = 3'd2,
    StTableFull = 3'd3,
    StUnknown   = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxTotal   = 2'd0,
    RegMaxPerAddr = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    ModeAdmit   = 1'b0,
    ModeRelease = 1'b1
  } mode_e;

  typedef struct packed {
    logic                 mode;
    logic [AddrHalfW-1:0] addr_upper;
    logic [AddrHalfW-1:0] addr_lower;
    logic                 management_port;
    logic                 release_tracked;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic              counted_per_address;
    logic [TotalW-1:0] total_now;
  } out_item_t;

endpackage

// ===== hw/rtl/connection_admission_limiter_unit.sv =====
`timescale 1ns / 1ps
// An accepted item is captured in the input register, then its result in the result register.
// Throughput: one item per cycle while the output is not stalled; all table entries are matched in parallel.
// The input side stalls only while a finished result is held by a stalled output.
// Reset (async, active low): clears limits, total count, entry valid bits and both
// pipeline valids; stored address keys and entry counts are not reset.
module connection_admission_limiter_unit
  import cal_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [TotalW-1:0]   max_total_q;
  logic [PerAddrW-1:0] max_per_addr_q;

  logic     s1_valid_q;
  in_item_t s1_item_q;

  logic [TotalW-1:0]    total_q, total_d;
  logic [AddrHalfW-1:0] key_upper_q [TableEntries];
  logic [AddrHalfW-1:0] key_lower_q [TableEntries];
  logic [CntW-1:0]      cnt_q       [TableEntries];
  logic [TableEntries-1:0] vld_q;

  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  logic advance, proc;
  logic [TableEntries-1:0] hit, at_lim, free_oh;
  logic any_hit, full, hit_at_lim;
  logic [LimTotalW-1:0] lim_total;
  logic [CntW-1:0]      lim_addr;
  logic too_many;
  logic do_alloc, do_bump, do_drop, total_inc, total_dec;
  logic counted;
  status_e status;

  assign advance     = !out_valid_q || !out_stall_i;
  assign proc        = s1_valid_q && advance;
  assign in_stall_o  = s1_valid_q && !advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit[i]    = vld_q[i] && (key_upper_q[i] == s1_item_q.addr_upper)
                           && (key_lower_q[i] == s1_item_q.addr_lower);
      at_lim[i] = cnt_q[i] >= lim_addr;
    end
  end

  assign any_hit    = |hit;
  assign hit_at_lim = |(hit & at_lim);
  assign full       = &vld_q;
  assign free_oh    = ~vld_q & (vld_q + TableEntries'(1));

  always_comb begin
    lim_total = {1'b0, max_total_q};
    lim_addr  = {1'b0, max_per_addr_q};
    if (s1_item_q.management_port) begin
      if (max_total_q != '0) begin
        lim_total = lim_total + LimTotalW'(MgmtTotalBonus);
      end
      if (max_per_addr_q != '0) begin
        lim_addr = lim_addr + CntW'(MgmtAddrBonus);
      end
    end
  end

  assign too_many = (total_q == '1) ||
                    ((lim_total != '0) && ({1'b0, total_q} >= lim_total));

  always_comb begin
    status    = StOk;
    counted   = 1'b0;
    do_alloc  = 1'b0;
    do_bump   = 1'b0;
    do_drop   = 1'b0;
    total_inc = 1'b0;
    total_dec = 1'b0;
    if (s1_item_q.mode == ModeAdmit) begin
      if (too_many) begin
        status = StTooMany;
      end else if (lim_addr == '0) begin
        total_inc = 1'b1;
      end else if (!any_hit) begin
        if (full) begin
          status = StTableFull;
        end else begin
          do_alloc  = 1'b1;
          total_inc = 1'b1;
          counted   = 1'b1;
        end
      end else if (hit_at_lim) begin
        status = StPerAddr;
      end else begin
        do_bump   = 1'b1;
        total_inc = 1'b1;
        counted   = 1'b1;
      end
    end else begin
      total_dec = total_q != '0;
      if (s1_item_q.release_tracked) begin
        if (!any_hit) begin
          status = StUnknown;
        end else begin
          do_drop = 1'b1;
        end
      end
    end
  end

  always_comb begin
    total_d = total_q;
    if (total_inc) begin
      total_d = total_q + TotalW'(1);
    end else if (total_dec) begin
      total_d = total_q - TotalW'(1);
    end
  end

  always_comb begin
    out_item_d.status              = status;
    out_item_d.counted_per_address = counted;
    out_item_d.total_now           = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_q    <= '0;
      max_per_addr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegMaxTotal:   max_total_q    <= cfg_data_i[TotalW-1:0];
        RegMaxPerAddr: max_per_addr_q <= cfg_data_i[PerAddrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      vld_q       <= '0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (proc) begin
        total_q <= total_d;
        for (int i = 0; i < TableEntries; i++) begin
          if (do_alloc && free_oh[i]) begin
            vld_q[i] <= 1'b1;
          end else if (do_drop && hit[i]) begin
            vld_q[i] <= cnt_q[i] > CntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_item_i;
    end
    if (proc) begin
      out_item_q <= out_item_d;
      for (int i = 0; i < TableEntries; i++) begin
        if (do_alloc && free_oh[i]) begin
          key_upper_q[i] <= s1_item_q.addr_upper;
          key_lower_q[i] <= s1_item_q.addr_lower;
          cnt_q[i]       <= CntW'(1);
        end else if (do_bump && hit[i]) begin
          cnt_q[i] <= cnt_q[i] + CntW'(1);
        end else if (do_drop && hit[i]) begin
          cnt_q[i] <= (cnt_q[i] != '0) ? cnt_q[i] - CntW'(1) : '0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/cal_checker.sv =====
`timescale 1ns / 1ps
`include "connection_admission_limiter_unit_defines.svh"
module cal_checker
  import cal_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  `CAL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `CAL_ASSERT_NOW(a_counted_ok, out_valid_o && out_item_o.counted_per_address, out_item_o.status == StOk && out_item_o.total_now != '0)
  `CAL_ASSERT_NOW(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  `CAL_ASSERT_NOW(a_reset_empty, $rose(rst_ni), !out_valid_o && !in_stall_o)

endmodule

bind connection_admission_limiter_unit cal_checker u_cal_checker (.*);
